// ===== hw/rtl/hkst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Held key slot tracker package
// Shared types and constants for the key slot chain and its control.
// ----------------------------------------------------------------------------
package hkst_pkg;

    // Widest supported slot table is sixteen cells
    localparam int SLOT_MAX   = 16;
    localparam int SLOT_IDX_W = 4;
    localparam int SLOT_CNT_W = 5;
    localparam int KEY_W      = 12;
    localparam int SLOT_W     = 16;

    localparam logic [SLOT_W-1:0] FORCE_MARK = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        OUTCOME_DONE     = 2'd0,
        OUTCOME_ALREADY  = 2'd1,
        OUTCOME_FULL     = 2'd2,
        OUTCOME_NOT_HELD = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_STORE,
        CMD_FREE,
        CMD_CLEAR_ALL,
        CMD_FORCE
    } cmd_kind_t;

    // Scan record handed from cell to cell
    typedef struct packed {
        logic                  hit;
        logic [SLOT_IDX_W-1:0] hit_idx;
        logic                  free;
        logic [SLOT_IDX_W-1:0] free_idx;
        logic [SLOT_CNT_W-1:0] busy;
    } scan_rec_t;

    // Update broadcast to every cell at commit
    typedef struct packed {
        cmd_kind_t             kind;
        logic [SLOT_IDX_W-1:0] idx;
        logic [SLOT_W-1:0]     key;
    } slot_cmd_t;

endpackage

// ===== hw/rtl/held_key_slot_tracker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Held key slot tracker
// Records which physical keys hold one action down in a chain of key
// slot cells, and keeps press and release edge flags.
// ----------------------------------------------------------------------------
// The scan record steps through one cell a cycle, then the commit state
// writes the result word, waiting while the previous result is untaken.
// One word is scanned at a time; a new word is taken once the commit is
// done, while the previous result may still wait in the result register.
// Reset: rst_n clears every slot, the down and edge flags and the result
// valid flag at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module held_key_slot_tracker_unit
    import hkst_pkg::*;
#(
    parameter int SLOT_COUNT = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] key_code, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] held, [1] went_down_flag,
                                   // [2] went_up_flag, [4:3] outcome,
                                   // [7:5] held_count
);

    localparam int CNT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SLOT_COUNT - 1);

    // ------------------------------------------------------------------
    // Input capture
    // ------------------------------------------------------------------
    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  step_reg;
    logic [CNT_W-1:0]  step_next;
    op_t               op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              accept;
    logic              commit_fire;

    logic              down_reg;
    logic              down_next;
    logic              went_down_reg;
    logic              went_down_next;
    logic              went_up_reg;
    logic              went_up_next;

    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic [7:0]        out_data_next;

    outcome_t          outcome;
    logic [SLOT_CNT_W-1:0] count_after;
    logic [2:0]        count_sat;
    slot_cmd_t         cmd;
    slot_cmd_t         cmd_plan;
    scan_rec_t         rec_chain [SLOT_COUNT+1];
    scan_rec_t         scan_res;
    logic [SLOT_W-1:0] scan_key;

    assign accept   = s_tvalid && s_tready;
    assign scan_key = SLOT_W'(key_reg);

    // Commit waits only while the result register is full and not being taken
    assign commit_fire = (state_reg == ST_COMMIT) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(s_tuser);
            key_reg <= s_tdata[KEY_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: idle, scan through the chain, commit
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (s_tvalid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                step_next = '0;
                if (commit_fire)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '{kind: CMD_NONE, idx: '0, key: '0};
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SCAN:   s_tready = 1'b0;
            ST_COMMIT: if (commit_fire) cmd = cmd_plan;
            default:   s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: the scan record enters cell 0 empty and steps one cell
    // a cycle; the last cell's record holds the lowest hit, lowest free
    // slot and the busy count.
    // ------------------------------------------------------------------
    assign rec_chain[0] = '0;

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        hkst_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .scan_key (scan_key),
            .rec_in   (rec_chain[i]),
            .rec_out  (rec_chain[i+1]),
            .cmd      (cmd)
        );
    end

    assign scan_res = rec_chain[SLOT_COUNT];

    // ------------------------------------------------------------------
    // Decide the slot update and flags from the finished scan
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd_plan       = '{kind: CMD_NONE, idx: '0, key: scan_key};
        outcome        = OUTCOME_DONE;
        count_after    = scan_res.busy;
        down_next      = down_reg;
        went_down_next = went_down_reg;
        went_up_next   = went_up_reg;
        case (op_reg)
            OP_PRESS:
            begin
                if (key_reg == '0)
                begin
                    // Console press: force the action on
                    cmd_plan.kind  = CMD_FORCE;
                    count_after    = SLOT_CNT_W'(1);
                    down_next      = 1'b1;
                    went_down_next = 1'b1;
                end
                else if (scan_res.hit)
                begin
                    outcome = OUTCOME_ALREADY;
                end
                else if (!scan_res.free)
                begin
                    outcome = OUTCOME_FULL;
                end
                else
                begin
                    cmd_plan.kind  = CMD_STORE;
                    cmd_plan.idx   = scan_res.free_idx;
                    count_after    = scan_res.busy + 1'b1;
                    down_next      = 1'b1;
                    went_down_next = 1'b1;
                end
            end
            OP_RELEASE:
            begin
                if (key_reg == '0)
                begin
                    // Console release: drop every slot
                    cmd_plan.kind = CMD_CLEAR_ALL;
                    count_after   = '0;
                    down_next     = 1'b0;
                    went_up_next  = 1'b1;
                end
                else if (!scan_res.hit)
                begin
                    outcome = OUTCOME_NOT_HELD;
                end
                else
                begin
                    cmd_plan.kind = CMD_FREE;
                    cmd_plan.idx  = scan_res.hit_idx;
                    count_after   = scan_res.busy - 1'b1;
                    went_up_next  = 1'b1;
                    if (scan_res.busy == SLOT_CNT_W'(1))
                        down_next = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                went_down_next = 1'b0;
                went_up_next   = 1'b0;
            end
            default:
            begin
                outcome = OUTCOME_DONE;
            end
        endcase
    end

    // Saturate the slot count into the three-bit field
    assign count_sat = (count_after > SLOT_CNT_W'(7)) ? 3'd7 : count_after[2:0];

    assign out_data_next = {count_sat, outcome, went_up_next, went_down_next, down_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg      <= 1'b0;
            went_down_reg <= 1'b0;
            went_up_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit_fire)
            begin
                down_reg      <= down_next;
                went_down_reg <= went_down_next;
                went_up_reg   <= went_up_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word register: hold until taken
    always_ff @(posedge clk)
    begin
        if (commit_fire)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_held_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[0] == (out_data_reg[7:5] != 3'd0)))
        else $error("held flag disagrees with slot count");

    a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second word taken while scan in progress");

    a_hit_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && scan_res.hit) |-> (scan_res.busy != '0))
        else $error("scan hit reported with no busy slot");

    a_cmd_only_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.kind != CMD_NONE) |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("slot update without result word");

endmodule

// ===== hw/rtl/hkst_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key slot cell
// Holds one key slot, folds it into the passing scan record and applies
// the commit command.
// ----------------------------------------------------------------------------
module hkst_cell
    import hkst_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] scan_key,
    input  scan_rec_t         rec_in,
    output scan_rec_t         rec_out,
    input  slot_cmd_t         cmd
);

    localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(CELL_IDX);

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    scan_rec_t         rec_reg;
    scan_rec_t         rec_next;
    logic              busy;
    logic              match;

    assign busy  = (slot_reg != '0);
    assign match = busy && (slot_reg == scan_key);

    // Fold this slot into the record: keep the lowest hit and lowest free
    always_comb
    begin
        rec_next = rec_in;
        if (!rec_in.hit && match)
        begin
            rec_next.hit     = 1'b1;
            rec_next.hit_idx = MY_IDX;
        end
        if (!rec_in.free && !busy)
        begin
            rec_next.free     = 1'b1;
            rec_next.free_idx = MY_IDX;
        end
        rec_next.busy = rec_in.busy + SLOT_CNT_W'(busy);
    end

    always_comb
    begin
        slot_next = slot_reg;
        unique case (cmd.kind)
            CMD_NONE:      slot_next = slot_reg;
            CMD_STORE:     if (cmd.idx == MY_IDX) slot_next = cmd.key;
            CMD_FREE:      if (cmd.idx == MY_IDX) slot_next = '0;
            CMD_CLEAR_ALL: slot_next = '0;
            CMD_FORCE:     slot_next = (CELL_IDX == 0) ? FORCE_MARK : '0;
            default:       slot_next = slot_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec_out = rec_reg;

endmodule
